>>> sv/hsv_pkg.sv
package hsv_pkg;

  localparam int unsigned SectorSpan = 43;
  localparam int unsigned FracScale  = 6;
  localparam int unsigned MulShift   = 8;
  localparam logic [7:0]  FullLevel  = 8'd255;

  typedef enum logic [2:0] {
    SEC_0 = 3'd0,
    SEC_1 = 3'd1,
    SEC_2 = 3'd2,
    SEC_3 = 3'd3,
    SEC_4 = 3'd4,
    SEC_5 = 3'd5
  } sector_e;

  // Start of sector k on the hue circle.
  localparam logic [7:0] Sec1Base = 8'(1 * SectorSpan);
  localparam logic [7:0] Sec2Base = 8'(2 * SectorSpan);
  localparam logic [7:0] Sec3Base = 8'(3 * SectorSpan);
  localparam logic [7:0] Sec4Base = 8'(4 * SectorSpan);
  localparam logic [7:0] Sec5Base = 8'(5 * SectorSpan);

  // (a * b) >> 8 on 8-bit levels.
  function automatic logic [7:0] scale_level(input logic [7:0] a, input logic [7:0] b);
    logic [15:0] prod;
    prod = a * b;
    return prod[15:MulShift];
  endfunction

endpackage

>>> sv/hsv_to_rgb_converter.sv
// Each accepted input word passes the stage 1, 2 and 3 registers in order.
// Throughput: one word per cycle; the stage valid bits let an item enter
// every cycle, and a stall at the output holds the full stages while empty
// ones still fill, so the input only blocks once all three stages are full.
// Stage 1 splits the hue, stage 2 does p and the s-level products, stage 3 the
// q and t products and channel select. Reset clears the stage valid bits only.
module hsv_to_rgb_converter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [7:0] hue_i,
  input  logic [7:0] saturation_i,
  input  logic [7:0] brightness_i,
  output logic       valid_o,
  input  logic       ready_i,
  output logic [7:0] red_o,
  output logic [7:0] green_o,
  output logic [7:0] blue_o
);
  import hsv_pkg::*;

  logic       en1, en2, en3;
  logic       vld1_q, vld2_q, vld3_q;

  // stage 1: sector and fraction
  sector_e    sec1_d, sec1_q;
  logic [7:0] base1;
  logic [7:0] rem1;
  logic [7:0] frac1_d, frac1_q;
  logic [7:0] sat1_q, val1_q;

  // stage 2: p and the two s-scaled fractions
  sector_e    sec2_q;
  logic [7:0] val2_q;
  logic [7:0] p2_d, p2_q;
  logic [7:0] sf2_d, sf2_q;
  logic [7:0] snf2_d, snf2_q;

  // stage 3: q, t and channel select
  logic [7:0] q3, t3;
  logic [7:0] red_d, green_d, blue_d;
  logic [7:0] red_q, green_q, blue_q;

  assign en3     = !vld3_q || ready_i;
  assign en2     = !vld2_q || en3;
  assign en1     = !vld1_q || en2;
  assign ready_o = en1;

  always_comb begin
    if (hue_i >= Sec5Base) begin
      sec1_d = SEC_5;
      base1  = Sec5Base;
    end else if (hue_i >= Sec4Base) begin
      sec1_d = SEC_4;
      base1  = Sec4Base;
    end else if (hue_i >= Sec3Base) begin
      sec1_d = SEC_3;
      base1  = Sec3Base;
    end else if (hue_i >= Sec2Base) begin
      sec1_d = SEC_2;
      base1  = Sec2Base;
    end else if (hue_i >= Sec1Base) begin
      sec1_d = SEC_1;
      base1  = Sec1Base;
    end else begin
      sec1_d = SEC_0;
      base1  = 8'd0;
    end
    rem1    = hue_i - base1;
    // remainder is at most 42, so times 6 stays in 8 bits
    frac1_d = 8'(rem1 * 8'(FracScale));
  end

  assign p2_d   = scale_level(val1_q, FullLevel - sat1_q);
  assign sf2_d  = scale_level(sat1_q, frac1_q);
  assign snf2_d = scale_level(sat1_q, FullLevel - frac1_q);

  assign q3 = scale_level(val2_q, FullLevel - sf2_q);
  assign t3 = scale_level(val2_q, FullLevel - snf2_q);

  always_comb begin
    unique case (sec2_q)
      SEC_0: begin
        red_d = val2_q; green_d = t3;     blue_d = p2_q;
      end
      SEC_1: begin
        red_d = q3;     green_d = val2_q; blue_d = p2_q;
      end
      SEC_2: begin
        red_d = p2_q;   green_d = val2_q; blue_d = t3;
      end
      SEC_3: begin
        red_d = p2_q;   green_d = q3;     blue_d = val2_q;
      end
      SEC_4: begin
        red_d = t3;     green_d = p2_q;   blue_d = val2_q;
      end
      default: begin
        red_d = val2_q; green_d = p2_q;   blue_d = q3;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else begin
      if (en1) vld1_q <= valid_i;
      if (en2) vld2_q <= vld1_q;
      if (en3) vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      sec1_q  <= sec1_d;
      frac1_q <= frac1_d;
      sat1_q  <= saturation_i;
      val1_q  <= brightness_i;
    end
    if (en2) begin
      sec2_q <= sec1_q;
      val2_q <= val1_q;
      p2_q   <= p2_d;
      sf2_q  <= sf2_d;
      snf2_q <= snf2_d;
    end
    if (en3) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign valid_o = vld3_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

>>> sv/hsv_chk.sv
module hsv_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       valid_i,
  input logic       ready_o,
  input logic [7:0] hue_i,
  input logic [7:0] saturation_i,
  input logic [7:0] brightness_i,
  input logic       valid_o,
  input logic       ready_i,
  input logic [7:0] red_o,
  input logic [7:0] green_o,
  input logic [7:0] blue_o
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(red_o) && $stable(green_o) && $stable(blue_o))
    else $error("output word changed while stalled");

  // input side only blocks when the output stage is full and the output stalls
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ready_o |-> valid_o && !ready_i)
    else $error("input blocked without a full stalled pipe");

  a_drain_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && ready_i |-> ready_o)
    else $error("input blocked while output drains");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o |-> ready_o)
    else $error("input blocked with empty output stage");

endmodule

bind hsv_to_rgb_converter hsv_chk u_hsv_chk (.*);

>>> tb/hsv_checker.sv
`timescale 1ns / 100ps

module hsv_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  hue_i,
  input  logic [7:0]  saturation_i,
  input  logic [7:0]  brightness_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  output int unsigned errors_o,
  output int unsigned pending_o
);
  import hsv_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  rgb_t expected_rgb[$];

  // (a * b) >> 8, kept to 8 bits
  function automatic logic [7:0] level_product(input logic [7:0] a, input logic [7:0] b);
    logic [15:0] full;
    full = 16'(a) * 16'(b);
    return full[15:8];
  endfunction

  function automatic rgb_t convert_hsv(input logic [7:0] h, input logic [7:0] s,
                                       input logic [7:0] v);
    sector_e    hue_sector;
    logic [7:0] offset;
    logic [7:0] frac;
    logic [7:0] p_lvl, q_lvl, t_lvl;
    rgb_t       rgb;
    hue_sector = sector_e'(3'(h / SectorSpan));
    offset     = h - 8'(hue_sector * SectorSpan);
    frac       = 8'(offset * FracScale);
    p_lvl      = level_product(v, FullLevel - s);
    q_lvl      = level_product(v, FullLevel - level_product(s, frac));
    t_lvl      = level_product(v, FullLevel - level_product(s, FullLevel - frac));
    case (hue_sector)
      SEC_0: rgb = '{red: v,     green: t_lvl, blue: p_lvl};
      SEC_1: rgb = '{red: q_lvl, green: v,     blue: p_lvl};
      SEC_2: rgb = '{red: p_lvl, green: v,     blue: t_lvl};
      SEC_3: rgb = '{red: p_lvl, green: q_lvl, blue: v};
      SEC_4: rgb = '{red: t_lvl, green: p_lvl, blue: v};
      default: rgb = '{red: v,   green: p_lvl, blue: q_lvl};
    endcase
    return rgb;
  endfunction

  always @(posedge clk_i) begin
    rgb_t        want;
    int unsigned bad;
    bad = 0;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        expected_rgb.push_back(convert_hsv(hue_i, saturation_i, brightness_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_rgb.size() == 0) begin
          $error("unexpected output word: red %0d green %0d blue %0d",
                 red_i, green_i, blue_i);
          bad++;
        end else begin
          want = expected_rgb.pop_front();
          if (red_i !== want.red) begin
            $error("red: expected %0d, got %0d", want.red, red_i);
            bad++;
          end
          if (green_i !== want.green) begin
            $error("green: expected %0d, got %0d", want.green, green_i);
            bad++;
          end
          if (blue_i !== want.blue) begin
            $error("blue: expected %0d, got %0d", want.blue, blue_i);
            bad++;
          end
        end
      end
      errors_o  <= errors_o + bad;
      pending_o <= expected_rgb.size();
    end
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned RandomWords = 1650;
  localparam int unsigned HoldOffAt   = 400;
  localparam int unsigned HoldOffLen  = 80;

  logic       clk_i;
  logic       rst_ni;
  logic       valid_i;
  logic       ready_o;
  logic [7:0] hue_i;
  logic [7:0] saturation_i;
  logic [7:0] brightness_i;
  logic       valid_o;
  logic       ready_i;
  logic [7:0] red_o;
  logic [7:0] green_o;
  logic [7:0] blue_o;

  int unsigned errors;
  int unsigned pending;
  int unsigned words_sent;

  hsv_to_rgb_converter uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_i),
    .ready_o      (ready_o),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .valid_o      (valid_o),
    .ready_i      (ready_i),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o)
  );

  hsv_checker checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (valid_i),
    .in_ready_i   (ready_o),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .out_valid_i  (valid_o),
    .out_ready_i  (ready_i),
    .red_i        (red_o),
    .green_i      (green_o),
    .blue_i       (blue_o),
    .errors_o     (errors),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input logic [7:0] h, input logic [7:0] s, input logic [7:0] v);
    valid_i      <= 1'b1;
    hue_i        <= h;
    saturation_i <= s;
    brightness_i <= v;
    @(posedge clk_i);
    while (!ready_o) @(posedge clk_i);
    words_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(1, 3));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Receiver: stretches of always-ready, coin-flip and mostly-stalled,
  // plus one long hold-off so the pipe fills and backs up the input.
  initial begin
    int unsigned stretch;
    int unsigned mode;
    bit          held;
    ready_i = 1'b0;
    held    = 1'b0;
    stretch = 0;
    mode    = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && words_sent >= HoldOffAt) begin
        held    = 1'b1;
        ready_i <= 1'b0;
        for (int unsigned n = 0; n < HoldOffLen; n++) @(negedge clk_i);
      end
      if (stretch == 0) begin
        stretch = $urandom_range(4, 40);
        mode    = $urandom_range(0, 2);
      end
      stretch--;
      case (mode)
        0: ready_i <= 1'b1;
        1: ready_i <= 1'($urandom_range(0, 1));
        default: ready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin
    int unsigned burst;
    int unsigned gap;
    int unsigned random_sent;
    valid_i      = 1'b0;
    hue_i        = '0;
    saturation_i = '0;
    brightness_i = '0;
    words_sent   = 0;
    @(posedge rst_ni);
    @(negedge clk_i);

    // sector edges at full saturation and brightness
    send_word(8'd0,   8'd255, 8'd255);
    send_word(8'd42,  8'd255, 8'd255);
    send_word(8'd43,  8'd255, 8'd255);
    send_word(8'd85,  8'd255, 8'd255);
    send_word(8'd86,  8'd255, 8'd255);
    send_word(8'd128, 8'd255, 8'd255);
    send_word(8'd129, 8'd255, 8'd255);
    send_word(8'd171, 8'd255, 8'd255);
    send_word(8'd172, 8'd255, 8'd255);
    send_word(8'd214, 8'd255, 8'd255);
    // last sector is short: its fraction tops out below the others
    send_word(8'd215, 8'd255, 8'd255);
    send_word(8'd255, 8'd255, 8'd255);
    // gray: helper levels sit one step below a nonzero value
    send_word(8'd0,   8'd0,   8'd255);
    send_word(8'd100, 8'd0,   8'd1);
    send_word(8'd255, 8'd0,   8'd0);
    send_word(8'd200, 8'd0,   8'd128);
    // dark and low-saturation corners
    send_word(8'd30,  8'd255, 8'd0);
    send_word(8'd60,  8'd1,   8'd255);
    send_word(8'd150, 8'd128, 8'd1);
    send_word(8'd170, 8'd170, 8'd85);
    send_word(8'd85,  8'd254, 8'd254);
    send_word(8'd240, 8'd85,  8'd170);

    random_sent = 0;
    while (random_sent < RandomWords) begin
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 16);
      for (int unsigned n = 0; n < burst && random_sent < RandomWords; n++) begin
        send_word(8'($urandom_range(0, 255)), pick_level(), pick_level());
        random_sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    valid_i <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/hsv_pkg.sv
sv/hsv_to_rgb_converter.sv
sv/hsv_chk.sv
tb/hsv_checker.sv
tb/tb_top.sv
